// ===== design/glmc_pkg.sv =====
`default_nettype none
package glmc_pkg;

	localparam int DIM_W = 7;
	localparam int COUNT_W = 13;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [DIM_W-1:0] DIM_MIN = 7'd2;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_index_t;

endpackage
`default_nettype wire

// ===== design/glmc_cell_if.sv =====
`default_nettype none
interface glmc_cell_if #(
	parameter int VALUE_WIDTH = 16
) ();
	logic valid;
	logic ready;
	logic signed [VALUE_WIDTH-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface
`default_nettype wire

// ===== design/glmc_count_if.sv =====
`default_nettype none
interface glmc_count_if
	import glmc_pkg::*;
();
	logic valid;
	logic ready;
	logic [COUNT_W-1:0] minimum_count;

	modport source (output valid, output minimum_count, input ready);
	modport sink (input valid, input minimum_count, output ready);
endinterface
`default_nettype wire

// ===== design/grid_local_minimum_counter.sv =====
// A frame's count is registered after the judging stage of its last cell. One cell per
// cycle while no count waits; the line memory has two read ports and one write port,
// and a write to a column still in flight is forwarded to the following read.
// Reset (asynchronous, active low) clears positions, the running count and the valid
// flags, and sets both dimensions to eight; the line memory is not cleared.
`default_nettype none
module grid_local_minimum_counter
	import glmc_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLUMNS = 64,
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	glmc_cell_if.sink                in_ch,
	glmc_count_if.source             out_ch,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic      [APB_DW-1:0]   prdata,
	output logic                     pready
);

	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam int ROW_LIM = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
	localparam int COL_LIM = (MAX_COLUMNS < DIM_MAX) ? MAX_COLUMNS : DIM_MAX;
	localparam int RW = $clog2(ROW_LIM);
	localparam int CW = $clog2(COL_LIM);
	localparam int XW = DIM_W + 1;
	localparam int EW = 2 * VALUE_WIDTH;

	logic [DIM_W-1:0] rows_q, cols_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [COUNT_W-1:0] count_q;

	logic [EW-1:0] line_mem [COL_LIM];

	logic valid_s1;
	logic signed [VALUE_WIDTH-1:0] x_s1;
	logic [CW-1:0] col_s1;
	logic r_ge1_s1, r_ge2_s1, r_last_s1, c_ge1_s1, c_ge2_s1, c_last_s1;
	logic [EW-1:0] rd_c_s1, rd_n_s1, fwd_data_s1;
	logic fwd_c_s1, fwd_n_s1;

	logic signed [VALUE_WIDTH-1:0] left_q, xprev_q, xprev2_q;
	logic out_valid_q;
	logic [COUNT_W-1:0] out_count_q;

	logic cfg_wr;
	reg_index_t cfg_idx;
	logic [DIM_W-1:0] wdat, row_new, col_new;
	logic in_acc, col_last, row_last;
	logic [CW-1:0] addr_n;

	logic [EW-1:0] ent_c, ent_n, wr_data;
	logic signed [VALUE_WIDTH-1:0] old_mid, up_c, mid_n;
	logic t_above, t_prev, t_last, frame_end;
	logic [COUNT_W:0] sum;
	logic [COUNT_W-1:0] count_next;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_idx = reg_index_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite;
	assign wdat = pwdata[DIM_W-1:0];

	always_comb begin
		if (wdat < DIM_MIN) begin
			row_new = DIM_MIN;
			col_new = DIM_MIN;
		end else begin
			row_new = (wdat > DIM_W'(ROW_LIM)) ? DIM_W'(ROW_LIM) : wdat;
			col_new = (wdat > DIM_W'(COL_LIM)) ? DIM_W'(COL_LIM) : wdat;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ROW_COUNT:    prdata = APB_DW'(rows_q);
			REG_COLUMN_COUNT: prdata = APB_DW'(cols_q);
			default:          prdata = '0;
		endcase
	end

	// Accept side.
	assign in_ch.ready = !(out_valid_q && !out_ch.ready);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign col_last = (XW'(col_q) + XW'(1)) == XW'(cols_q);
	assign row_last = (XW'(row_q) + XW'(1)) == XW'(rows_q);
	assign addr_n = col_last ? col_q : col_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROW_COUNT:    rows_q <= row_new;
				REG_COLUMN_COUNT: cols_q <= col_new;
				default:          rows_q <= rows_q;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1 <= in_ch.cell_value;
			col_s1 <= col_q;
			r_ge1_s1 <= (row_q != '0);
			r_ge2_s1 <= (row_q != '0) && (row_q != RW'(1));
			r_last_s1 <= row_last;
			c_ge1_s1 <= (col_q != '0);
			c_ge2_s1 <= (col_q != '0) && (col_q != CW'(1));
			c_last_s1 <= col_last;
			rd_c_s1 <= line_mem[col_q];
			rd_n_s1 <= line_mem[addr_n];
			fwd_c_s1 <= valid_s1 && (col_s1 == col_q);
			fwd_n_s1 <= valid_s1 && (col_s1 == addr_n);
			fwd_data_s1 <= wr_data;
		end
		if (valid_s1) begin
			line_mem[col_s1] <= wr_data;
		end
	end

	// Judging stage: each entry holds the two previous rows of its column.
	assign ent_c = fwd_c_s1 ? fwd_data_s1 : rd_c_s1;
	assign ent_n = fwd_n_s1 ? fwd_data_s1 : rd_n_s1;
	assign old_mid = ent_c[VALUE_WIDTH-1:0];
	assign up_c = ent_c[EW-1:VALUE_WIDTH];
	assign mid_n = ent_n[VALUE_WIDTH-1:0];
	assign wr_data = {old_mid, x_s1};

	assign t_above = r_ge1_s1 && (!r_ge2_s1 || (old_mid < up_c)) && (old_mid < x_s1)
		&& (!c_ge1_s1 || (old_mid < left_q)) && (c_last_s1 || (old_mid < mid_n));
	assign t_prev = r_last_s1 && c_ge1_s1 && (xprev_q < left_q)
		&& (!c_ge2_s1 || (xprev_q < xprev2_q)) && (xprev_q < x_s1);
	assign t_last = r_last_s1 && c_last_s1 && (x_s1 < old_mid) && (x_s1 < xprev_q);
	assign frame_end = r_last_s1 && c_last_s1;

	assign sum = (COUNT_W+1)'(count_q) + (COUNT_W+1)'(t_above) + (COUNT_W+1)'(t_prev)
		+ (COUNT_W+1)'(t_last);
	assign count_next = (sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_q <= old_mid;
			xprev_q <= x_s1;
			xprev2_q <= xprev_q;
		end
		if (valid_s1 && frame_end) begin
			out_count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				count_q <= '0;
			end else if (valid_s1) begin
				count_q <= frame_end ? '0 : count_next;
			end
			if (valid_s1 && frame_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.minimum_count = out_count_q;

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && frame_end |-> !out_valid_q)
		else $error("frame count produced while the output register is occupied");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(col_q) < XW'(cols_q))
		else $error("column position outside the frame");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && frame_end |=> count_q == '0)
		else $error("running count not cleared after frame end");
	a_out_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && frame_end |=> out_valid_q && out_count_q == $past(count_next))
		else $error("frame count not presented after frame end");
`endif

endmodule
`default_nettype wire

// ===== tb/glmc_minima_check.sv =====
`default_nettype none
module glmc_minima_check
	import glmc_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLUMNS = 64,
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	glmc_cell_if                   cell_ch,
	glmc_count_if                  cnt_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output int                     errors,
	output int                     pending,
	output int                     frames_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [VALUE_WIDTH-1:0] cell_t;

	cell_t upper_line [MAX_COLUMNS];
	cell_t middle_line [MAX_COLUMNS];
	cell_t left_cell;
	int unsigned frame_rows;
	int unsigned frame_cols;
	int unsigned row_at;
	int unsigned col_at;
	logic [COUNT_W-1:0] minima;
	logic [COUNT_W-1:0] counts_due [$];
	logic [COUNT_W-1:0] want_count;
	int n_errors = 0;
	int n_frames = 0;

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] raw, int unsigned ceiling);
		if (raw < DIM_MIN) return DIM_MIN;
		if (raw > ceiling) return ceiling;
		return raw;
	endfunction

	function automatic bit strictly_lowest(cell_t centre, bit has_up, cell_t up_v,
			bit has_down, cell_t down_v, bit has_left, cell_t left_v,
			bit has_right, cell_t right_v);
		return (!has_up || centre < up_v) && (!has_down || centre < down_v) &&
			(!has_left || centre < left_v) && (!has_right || centre < right_v);
	endfunction

	function automatic void tally_minimum(bit hit);
		if (hit && minima != COUNT_MAX) minima++;
	endfunction

	function automatic void restart_frame();
		row_at = 0;
		col_at = 0;
		minima = '0;
	endfunction

	// Each cell completes the judgement of the cell above it; the last row is
	// judged along the row as soon as each right neighbour is in.
	function automatic void judge_cell(cell_t x);
		int unsigned r;
		int unsigned c;
		cell_t old_mid;
		cell_t right_v;
		bit has_right;
		if (row_at >= frame_rows || col_at >= frame_cols) restart_frame();
		r = row_at;
		c = col_at;
		old_mid = middle_line[c];
		if (r >= 1) begin
			has_right = (c + 1 < frame_cols);
			right_v = has_right ? middle_line[c + 1] : '0;
			tally_minimum(strictly_lowest(old_mid, r >= 2, upper_line[c], 1'b1, x,
				c >= 1, left_cell, has_right, right_v));
		end
		upper_line[c] = old_mid;
		middle_line[c] = x;
		left_cell = old_mid;
		if (r + 1 == frame_rows) begin
			if (c >= 1)
				tally_minimum(strictly_lowest(middle_line[c - 1], 1'b1, upper_line[c - 1],
					1'b0, '0, c >= 2, (c >= 2) ? middle_line[c - 2] : '0,
					1'b1, middle_line[c]));
			if (c + 1 == frame_cols)
				tally_minimum(strictly_lowest(middle_line[c], 1'b1, upper_line[c],
					1'b0, '0, 1'b1, middle_line[c - 1], 1'b0, '0));
		end
		if (c + 1 < frame_cols) begin
			col_at = c + 1;
		end else begin
			col_at = 0;
			if (r + 1 < frame_rows) begin
				row_at = r + 1;
			end else begin
				counts_due.push_back(minima);
				restart_frame();
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			left_cell = '0;
			frame_rows = DIM_RESET;
			frame_cols = DIM_RESET;
			restart_frame();
			counts_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[2]))
					REG_ROW_COUNT: frame_rows = fit_dim(pwdata[DIM_W-1:0], MAX_ROWS);
					REG_COLUMN_COUNT: frame_cols = fit_dim(pwdata[DIM_W-1:0], MAX_COLUMNS);
				endcase
				restart_frame();
			end
			if (cell_ch.valid && cell_ch.ready) judge_cell(cell_ch.cell_value);
			if (cnt_ch.valid && cnt_ch.ready) begin
				if (counts_due.size() == 0) begin
					n_errors++;
					$display("%0t: minimum_count expected none, got %0d", $time,
						cnt_ch.minimum_count);
				end else begin
					want_count = counts_due.pop_front();
					n_frames++;
					if (cnt_ch.minimum_count !== want_count) begin
						n_errors++;
						$display("%0t: minimum_count expected %0d, got %0d", $time,
							want_count, cnt_ch.minimum_count);
					end
				end
			end
			pending <= counts_due.size();
		end
		errors <= n_errors;
		frames_checked <= n_frames;
	end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import glmc_pkg::*;

	localparam int CELL_BUDGET = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_AREA = 256;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_SLOW} rx_mode_t;
	typedef enum {FILL_FULL, FILL_NARROW, FILL_EDGES} fill_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	glmc_cell_if #(.VALUE_WIDTH(16)) cell_ch();
	glmc_count_if cnt_ch();

	int errors;
	int pending;
	int frames_checked;
	int cells_sent = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int unsigned cur_rows;
	int unsigned cur_cols;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;

	grid_local_minimum_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cell_ch),
		.out_ch(cnt_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	glmc_minima_check check_i (
		.clk(clk),
		.arst_n(arst_n),
		.cell_ch(cell_ch),
		.cnt_ch(cnt_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending),
		.frames_checked(frames_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (cnt_ch.valid && cnt_ch.ready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cnt_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(40, 300);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN: cnt_ch.ready <= 1'b1;
				RX_COIN: cnt_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: cnt_ch.ready <= ($urandom_range(0, 7) == 0);
				RX_SLOW: cnt_ch.ready <= (rx_tick % 24 == 0);
			endcase
		end
	end

	function automatic int unsigned span(logic [31:0] raw);
		if (raw[DIM_W-1:0] < DIM_MIN) return DIM_MIN;
		if (raw[DIM_W-1:0] > 64) return 64;
		return raw[DIM_W-1:0];
	endfunction

	function automatic logic [31:0] dim_choice();
		logic [31:0] raw;
		case ($urandom_range(0, 11))
			0: raw = 0;
			1: raw = 1;
			2: raw = 64;
			3: raw = 127;
			4: raw = $urandom_range(9, 32);
			default: raw = $urandom_range(2, 6);
		endcase
		if ($urandom_range(0, 1) == 1) raw = raw | ($urandom & 32'hFFFF_FF80);
		return raw;
	endfunction

	function automatic logic signed [15:0] cell_sample(fill_t how);
		int pick;
		case (how)
			FILL_FULL: return 16'($urandom);
			FILL_NARROW: begin
				pick = $urandom_range(0, 4);
				return 16'(pick - 2);
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh8001;
					2: return 16'sh7FFF;
					3: return 16'sh7FFE;
					4: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
		endcase
	endfunction

	task automatic push_cell(input logic signed [15:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cell_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cell_ch.valid <= 1'b1;
		cell_ch.cell_value <= v;
		do @(posedge clk); while (!cell_ch.ready);
		burst_left--;
		cells_sent++;
	endtask

	task automatic send_frame(input fill_t how, input int unsigned n);
		repeat (n) push_cell(cell_sample(how));
	endtask

	// Holds the sender off until every frame count is out and the block has drained.
	task automatic settle();
		cell_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		reg_writes++;
		if (idx == REG_ROW_COUNT) cur_rows = span(data);
		else cur_cols = span(data);
	endtask

	task automatic configure(input logic [31:0] rows_raw, input logic [31:0] cols_raw,
			input bit set_rows, input bit set_cols);
		settle();
		if (set_rows) write_reg(REG_ROW_COUNT, rows_raw);
		if (set_cols) write_reg(REG_COLUMN_COUNT, cols_raw);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [31:0] rows_raw;
		logic [31:0] cols_raw;
		int which;
		int unsigned area;
		int frames;
		arst_n = 1'b0;
		cell_ch.valid = 1'b0;
		cell_ch.cell_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_rows = DIM_RESET;
		cur_cols = DIM_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(FILL_NARROW, cur_rows * cur_cols);

		configure(32'hFFFF_FF80, 32'h0000_0001, 1'b1, 1'b1);
		push_cell(16'sh8000);
		push_cell(16'sh7FFF);
		push_cell(16'sh7FFF);
		push_cell(16'sh8000);
		repeat (4) push_cell(16'sd5);
		configure(32'd3, 32'd3, 1'b1, 1'b1);
		for (int i = 0; i < 9; i++) push_cell((i == 4) ? -16'sd1 : 16'sd0);
		push_cell(16'sh7FFF);
		push_cell(16'sh8000);
		push_cell(16'sd1);
		push_cell(-16'sd2);

		while (cells_sent < CELL_BUDGET) begin
			rows_raw = dim_choice();
			cols_raw = dim_choice();
			which = $urandom_range(0, 3);
			if ((which != 1 ? span(rows_raw) : cur_rows) *
					(which != 2 ? span(cols_raw) : cur_cols) > MAX_AREA) begin
				cols_raw = $urandom_range(2, 4);
				which = 0;
			end
			configure(rows_raw, cols_raw, which != 1, which != 2);
			quiet = ($urandom_range(0, 3) == 0);
			area = cur_rows * cur_cols;
			frames = (area <= 16) ? $urandom_range(2, 6) :
				(area <= 64) ? $urandom_range(1, 3) : 1;
			repeat (frames) send_frame(fill_t'($urandom_range(0, 2)), area);
			if ($urandom_range(0, 3) == 0)
				send_frame(FILL_FULL, $urandom_range(1, area - 1));
		end
		settle();

		$display("summary: %0d cells sent, %0d frame counts checked, %0d register writes",
			cells_sent, frames_checked, reg_writes);
		$display("summary: frames from 2 to 64 rows and columns, cut short and clamped");
		if (errors == 0 && pending == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
